### sv/cuckoo_pkg.sv
`timescale 1ns / 1ps
// Package for the two-table cuckoo hash map: request and response words,
// slot word layout, request and status codes. No dependencies.
package cuckoo_pkg;

  localparam int KEY_W  = 31;
  localparam int VAL_W  = 31;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_PUT    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GET    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FAIL = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_value;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

endpackage

### sv/cuckoo_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cuckoo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/cuckoo_cdiv.sv
`timescale 1ns / 1ps
// Two-stage divider of a 31-bit word by a constant, by exact reciprocal
// multiplication; quotient and remainder registered. Uses cuckoo_pkg.
module cuckoo_cdiv
  import cuckoo_pkg::*;
#(
  parameter int DIVISOR = 64
) (
  input  logic                       clk_i,
  input  logic [KEY_W-1:0]           x_i,
  output logic [KEY_W-1:0]           q_o,
  output logic [$clog2(DIVISOR)-1:0] r_o
);

  localparam int          LOG_D   = $clog2(DIVISOR);
  localparam int          SHIFT   = KEY_W + LOG_D;
  localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [31:0] RECIP   = RECIP64[31:0];
  localparam logic [KEY_W-1:0] DIV_W = KEY_W'(DIVISOR);
  localparam int          PROD_W  = KEY_W + 32;

  logic [PROD_W-1:0] prod_q;
  logic [KEY_W-1:0]  x_q;
  logic [PROD_W-1:0] prod_d;
  logic [KEY_W-1:0]  quot;
  logic [KEY_W-1:0]  back;
  logic [KEY_W-1:0]  diff;

  assign prod_d = PROD_W'(x_i) * PROD_W'(RECIP);
  assign quot   = KEY_W'(prod_q >> SHIFT);
  assign back   = quot * DIV_W;
  assign diff   = x_q - back;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    x_q    <= x_i;
    q_o    <= quot;
    r_o    <= diff[LOG_D-1:0];
  end

endmodule

### sv/cuckoo_hash_table_core.sv
`timescale 1ns / 1ps
// Top level of the two-table cuckoo hash map: sequencer, shared constant
// divider and slot RAM. Uses cuckoo_pkg, cuckoo_cdiv and cuckoo_ram.
//
// Input channel in_valid_i/in_ready_o carries a request word (put, get,
// remove with key and value). Output channel out_valid_o/out_ready_i carries
// one response word per request (status and read value).
// After reset the block clears the valid flags of all 2*HALF_SLOTS slots,
// one slot a cycle, and holds in_ready_o low until all of them are clear.
// One request is worked at a time. Hashing a key takes two passes through
// the shared two-stage constant divider (key mod HALF_SLOTS, then quotient
// mod HALF_SLOTS), followed by two RAM reads and a decision step: a get,
// remove or put without displacement then loads its response into the
// output register from the done state and returns to idle to take the next
// request. Each displacement of a put adds a rehash of the evicted key and
// one RAM read, at most MAX_KICKS times.
// The response sits in an output register; if the receiver stalls, the
// finished response waits in res_q until that register is free, and the
// block accepts the next request only after moving it into the register.
module cuckoo_hash_table_core
  import cuckoo_pkg::*;
#(
  parameter int HALF_SLOTS = 64,
  parameter int MAX_KICKS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int SLOTS = 2 * HALF_SLOTS;
  localparam int SAW   = $clog2(SLOTS);
  localparam int HAW   = $clog2(HALF_SLOTS);
  localparam int KW    = $clog2(MAX_KICKS + 1);
  localparam logic [SAW-1:0] HALF_A = SAW'(HALF_SLOTS);
  localparam logic [SAW-1:0] LAST_A = SAW'(SLOTS - 1);
  localparam logic [KW-1:0]  KICK_LIM = KW'(MAX_KICKS);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_H1    = 4'd2;
  localparam logic [3:0] ST_H2    = 4'd3;
  localparam logic [3:0] ST_H3    = 4'd4;
  localparam logic [3:0] ST_H4    = 4'd5;
  localparam logic [3:0] ST_H5    = 4'd6;
  localparam logic [3:0] ST_RDB   = 4'd7;
  localparam logic [3:0] ST_CHK   = 4'd8;
  localparam logic [3:0] ST_KCHK  = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [SAW-1:0]   clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  logic             kick_q, kick_d;
  logic             second_q, second_d;
  logic [KW-1:0]    kicks_q, kicks_d;

  logic [REQ_W-1:0] rq_q, rq_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [SAW-1:0]   a_q, a_d;
  logic [SAW-1:0]   b_q, b_d;
  logic [SAW-1:0]   idx_q, idx_d;
  slot_t            da_q, da_d;
  rsp_t             res_q, res_d;
  rsp_t             out_q, out_d;

  logic [KEY_W-1:0] div_x;
  logic [KEY_W-1:0] div_q;
  logic [HAW-1:0]   div_r;
  logic [SAW-1:0]   b_now;

  logic             we;
  logic [SAW-1:0]   waddr;
  slot_t            wdata;
  logic [SAW-1:0]   raddr;
  logic [$bits(slot_t)-1:0] rdata;
  slot_t            rd;
  slot_t            put_word;
  logic             hit_a, hit_b;

  assign rd       = slot_t'(rdata);
  assign put_word = '{valid: 1'b1, key: key_q, value: val_q};
  assign b_now    = SAW'(div_r) + HALF_A;
  assign hit_a    = da_q.valid && (da_q.key == key_q);
  assign hit_b    = rd.valid && (rd.key == key_q);
  assign div_x    = (state_q == ST_H3) ? div_q : key_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  cuckoo_cdiv #(
    .DIVISOR(HALF_SLOTS)
  ) u_cdiv (
    .clk_i (clk_i),
    .x_i   (div_x),
    .q_o   (div_q),
    .r_o   (div_r)
  );

  cuckoo_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    kick_d      = kick_q;
    second_d    = second_q;
    kicks_d     = kicks_q;
    rq_d        = rq_q;
    key_d       = key_q;
    val_d       = val_q;
    a_d         = a_q;
    b_d         = b_q;
    idx_d       = idx_q;
    da_d        = da_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    we          = 1'b0;
    waddr       = a_q;
    wdata       = put_word;
    raddr       = a_q;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_A) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          rq_d     = in_data_i.req_type;
          key_d    = in_data_i.key;
          val_d    = in_data_i.value;
          kick_d   = 1'b0;
          second_d = 1'b0;
          kicks_d  = '0;
          state_d  = ST_H1;
        end
      end
      ST_H1: state_d = ST_H2;
      ST_H2: state_d = ST_H3;
      ST_H3: begin
        a_d     = SAW'(div_r);
        state_d = ST_H4;
      end
      ST_H4: state_d = ST_H5;
      ST_H5: begin
        b_d = b_now;
        if (kick_q) begin
          raddr   = second_q ? b_now : a_q;
          idx_d   = raddr;
          state_d = ST_KCHK;
        end else begin
          raddr   = a_q;
          state_d = ST_RDB;
        end
      end
      ST_RDB: begin
        raddr   = b_q;
        da_d    = rd;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        res_d   = '{status: STAT_OK, read_value: '0};
        state_d = ST_DONE;
        priority case (rq_q)
          REQ_PUT: begin
            priority if (hit_a) begin
              we    = 1'b1;
              waddr = a_q;
            end else if (hit_b) begin
              we    = 1'b1;
              waddr = b_q;
            end else if (!da_q.valid) begin
              we    = 1'b1;
              waddr = a_q;
            end else if (!rd.valid) begin
              we    = 1'b1;
              waddr = b_q;
            end else begin
              we       = 1'b1;
              waddr    = a_q;
              key_d    = da_q.key;
              val_d    = da_q.value;
              kicks_d  = KW'(1);
              second_d = 1'b1;
              kick_d   = 1'b1;
              state_d  = ST_H1;
            end
          end
          REQ_GET: begin
            priority if (hit_a) begin
              res_d.read_value = da_q.value;
            end else if (hit_b) begin
              res_d.read_value = rd.value;
            end else begin
              res_d.status = STAT_MISS;
            end
          end
          REQ_REMOVE: begin
            priority if (hit_a) begin
              we    = 1'b1;
              waddr = a_q;
              wdata = '{valid: 1'b0, key: da_q.key, value: da_q.value};
            end else if (hit_b) begin
              we    = 1'b1;
              waddr = b_q;
              wdata = '{valid: 1'b0, key: rd.key, value: rd.value};
            end else begin
              res_d.status = STAT_MISS;
            end
          end
          default: begin
          end
        endcase
      end
      ST_KCHK: begin
        res_d   = '{status: STAT_OK, read_value: '0};
        waddr   = idx_q;
        state_d = ST_DONE;
        priority if (!rd.valid) begin
          we = 1'b1;
        end else if (kicks_q == KICK_LIM) begin
          res_d.status = STAT_FAIL;
        end else begin
          we       = 1'b1;
          key_d    = rd.key;
          val_d    = rd.value;
          kicks_d  = kicks_q + 1'b1;
          second_d = ~second_q;
          state_d  = ST_H1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      kick_q      <= 1'b0;
      second_q    <= 1'b0;
      kicks_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      kick_q      <= kick_d;
      second_q    <= second_d;
      kicks_q     <= kicks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q  <= rq_d;
    key_q <= key_d;
    val_q <= val_d;
    a_q   <= a_d;
    b_q   <= b_d;
    idx_q <= idx_d;
    da_q  <= da_d;
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule
